[src/dcmq_pkg.sv]
// ----------------------------------------------------------------------------
// dcmq_pkg
// Shared types and constants of the matrix to quaternion converter.
// ----------------------------------------------------------------------------
package dcmq_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int NORM_MSB      = 30;   // largest magnitude lands in [2^30, 2^31)
	localparam int MAG_W         = 31;   // magnitude after normalizing shift
	localparam int RAW_W         = 35;   // signed width of unscaled components
	localparam int ABS_W         = 34;   // magnitude width of unscaled components
	localparam int SUM_W         = 64;   // sum of four squares
	localparam int NRM_W         = 32;   // integer square root of the sum
	localparam int SQRT_STEPS    = 32;

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_D0,
		BR_D1,
		BR_D2
	} dcmq_branch_t;

	typedef struct packed {
		logic signed [31:0] e_c0r0;
		logic signed [31:0] e_c0r1;
		logic signed [31:0] e_c0r2;
		logic signed [31:0] e_c1r0;
		logic signed [31:0] e_c1r1;
		logic signed [31:0] e_c1r2;
		logic signed [31:0] e_c2r0;
		logic signed [31:0] e_c2r1;
		logic signed [31:0] e_c2r2;
	} dcmq_in_t;

	typedef struct packed {
		logic signed [31:0] quat_s;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic               degenerate;
	} dcmq_out_t;

	// data riding alongside the square root
	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic                  degen;
	} dcmq_side_t;

endpackage

[src/dcmq_isqrt.sv]
// ----------------------------------------------------------------------------
// dcmq_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dcmq_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [dcmq_pkg::SUM_W-1:0]  in_sum,
	input  dcmq_pkg::dcmq_side_t        in_side,
	output logic                        out_valid,
	output logic [dcmq_pkg::NRM_W-1:0]  out_nrm,
	output dcmq_pkg::dcmq_side_t        out_side
);
	import dcmq_pkg::*;

	logic             v_s    [0:SQRT_STEPS];
	logic [SUM_W-1:0] n_s    [0:SQRT_STEPS];
	logic [SUM_W-1:0] res_s  [0:SQRT_STEPS];
	dcmq_side_t       side_s [0:SQRT_STEPS];

	assign v_s[0]    = in_valid;
	assign n_s[0]    = in_sum;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic [SUM_W-1:0] trial;
		logic             take;

		assign trial = res_s[k] + BIT;
		assign take  = n_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= take ? n_s[k] - trial : n_s[k];
				res_s[k+1]  <= take ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS];
	assign out_nrm   = res_s[SQRT_STEPS][NRM_W-1:0];
	assign out_side  = side_s[SQRT_STEPS];

endmodule

[src/dcmq_div.sv]
// ----------------------------------------------------------------------------
// dcmq_div
// Four-lane pipelined restoring divider, one quotient bit per stage; forms
// (mag * 2^FRAC_BITS + nrm/2) / nrm for each component.
// ----------------------------------------------------------------------------
module dcmq_div #(
	parameter int FRAC_BITS = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [dcmq_pkg::NRM_W-1:0]  in_nrm,
	input  dcmq_pkg::dcmq_side_t        in_side,
	output logic                        out_valid,
	output logic [3:0][FRAC_BITS:0]     out_quo,
	output logic [3:0]                  out_neg,
	output logic                        out_degen
);
	import dcmq_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 32;

	logic                  v_s     [0:QW];
	logic [NRM_W-1:0]      d_s     [0:QW];
	logic [3:0]            neg_s   [0:QW];
	logic                  degen_s [0:QW];
	logic [3:0][DW-1:0]    rem_s   [0:QW];
	logic [3:0][QW-1:0]    quo_s   [0:QW];

	assign v_s[0]     = in_valid;
	assign d_s[0]     = in_nrm;
	assign neg_s[0]   = in_side.neg;
	assign degen_s[0] = in_side.degen;

	for (genvar l = 0; l < 4; l++) begin : g_init
		assign rem_s[0][l] = (DW'(in_side.mag[l]) << FRAC_BITS) + DW'(in_nrm >> 1);
		assign quo_s[0][l] = '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int J = QW - 1 - k;
		logic [DW-1:0]      dsh;
		logic [3:0][DW-1:0] rem_nx;
		logic [3:0][QW-1:0] quo_nx;

		assign dsh = DW'(d_s[k]) << J;

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				rem_nx[l] = rem_s[k][l];
				quo_nx[l] = quo_s[k][l];
				if (rem_s[k][l] >= dsh) begin
					rem_nx[l]    = rem_s[k][l] - dsh;
					quo_nx[l][J] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]     <= d_s[k];
				neg_s[k+1]   <= neg_s[k];
				degen_s[k+1] <= degen_s[k];
				rem_s[k+1]   <= rem_nx;
				quo_s[k+1]   <= quo_nx;
			end
		end
	end

	assign out_valid = v_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_neg   = neg_s[QW];
	assign out_degen = degen_s[QW];

endmodule

[src/dcm_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// dcm_to_quaternion_unit
// Direction cosine matrix to unit quaternion converter (Shepperd's method).
// ----------------------------------------------------------------------------
// Usage:
//   req carries one 3x3 matrix (nine signed fixed-point elements, column by
//   column) on a valid/ready channel; rsp returns the normalized quaternion
//   and a degenerate flag on a valid/ready channel.
//   The whole pipeline advances as one: a new matrix is taken every cycle
//   while rsp is empty or being taken, so throughput is one item per cycle.
//   The pipeline has FRAC_BITS + 40 register stages (39 + 31 = 70 at the
//   default): six stages of branch select, magnitude, largest magnitude,
//   shift normalization, squaring and summing, 32 square root stages,
//   FRAC_BITS+1 divider stages and the output register.
//   When rsp_ready is low with a result waiting, every stage holds and
//   req_ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module dcm_to_quaternion_unit #(
	parameter int FRAC_BITS = dcmq_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dcmq_pkg::dcmq_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dcmq_pkg::dcmq_out_t rsp
);
	import dcmq_pkg::*;

	localparam logic signed [RAW_W-1:0] ONE     = RAW_W'(1) << FRAC_BITS;
	localparam logic signed [RAW_W-1:0] RAD_MIN = RAW_W'(1) << (FRAC_BITS - 16);

	logic en;
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// stage 1: trace test, branch choice, radicand and off-diagonal terms
	logic signed [RAW_W-1:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
	logic signed [RAW_W-1:0] trace;
	dcmq_branch_t            br;
	logic signed [RAW_W-1:0] rad;

	always_comb begin
		c00   = RAW_W'(req.e_c0r0);
		c01   = RAW_W'(req.e_c0r1);
		c02   = RAW_W'(req.e_c0r2);
		c10   = RAW_W'(req.e_c1r0);
		c11   = RAW_W'(req.e_c1r1);
		c12   = RAW_W'(req.e_c1r2);
		c20   = RAW_W'(req.e_c2r0);
		c21   = RAW_W'(req.e_c2r1);
		c22   = RAW_W'(req.e_c2r2);
		trace = c00 + c11 + c22;
		if (trace >= 0) begin
			br  = BR_TRACE;
			rad = trace + ONE;
		end else if (c00 >= c11 && c00 >= c22) begin
			br  = BR_D0;
			rad = c00 - c11 - c22 + ONE;
		end else if (c11 >= c22 && c11 >= c00) begin
			br  = BR_D1;
			rad = c11 - c22 - c00 + ONE;
		end else begin
			br  = BR_D2;
			rad = c22 - c00 - c11 + ONE;
		end
	end

	logic                    v_s1;
	dcmq_branch_t            br_s1;
	logic signed [RAW_W-1:0] rad_s1, ta_s1, tb_s1, tc_s1, td_s1, te_s1, tf_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			br_s1  <= br;
			rad_s1 <= rad;
			ta_s1  <= c21 - c12;
			tb_s1  <= c02 - c20;
			tc_s1  <= c10 - c01;
			td_s1  <= c01 + c10;
			te_s1  <= c20 + c02;
			tf_s1  <= c12 + c21;
		end
	end

	// stage 2: clamp, component placement, magnitudes
	logic signed [RAW_W-1:0] rad_c;
	logic                    clamp;
	logic signed [RAW_W-1:0] q [4];

	always_comb begin
		clamp = (br_s1 != BR_TRACE) && (rad_s1 < RAD_MIN);
		rad_c = clamp ? RAD_MIN : rad_s1;
		case (br_s1)
			BR_TRACE: begin
				q[0] = rad_c; q[1] = ta_s1; q[2] = tb_s1; q[3] = tc_s1;
			end
			BR_D0: begin
				q[0] = ta_s1; q[1] = rad_c; q[2] = td_s1; q[3] = te_s1;
			end
			BR_D1: begin
				q[0] = tb_s1; q[1] = td_s1; q[2] = rad_c; q[3] = tf_s1;
			end
			default: begin
				q[0] = tc_s1; q[1] = te_s1; q[2] = tf_s1; q[3] = rad_c;
			end
		endcase
	end

	logic                   v_s2, degen_s2;
	dcmq_branch_t           br_s2;
	logic [3:0][ABS_W-1:0]  abs_s2;
	logic [3:0]             neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s2 <= clamp;
			br_s2    <= br_s1;
			for (int i = 0; i < 4; i++) begin
				neg_s2[i] <= q[i] < 0;
				abs_s2[i] <= q[i] < 0 ? ABS_W'(-q[i]) : ABS_W'(q[i]);
			end
		end
	end

	// stage 3: largest magnitude
	logic [ABS_W-1:0] mx01, mx23;
	assign mx01 = abs_s2[0] > abs_s2[1] ? abs_s2[0] : abs_s2[1];
	assign mx23 = abs_s2[2] > abs_s2[3] ? abs_s2[2] : abs_s2[3];

	logic                  v_s3, degen_s3;
	logic [ABS_W-1:0]      mx_s3;
	logic [3:0][ABS_W-1:0] abs_s3;
	logic [3:0]            neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3    <= mx01 > mx23 ? mx01 : mx23;
			abs_s3   <= abs_s2;
			neg_s3   <= neg_s2;
			degen_s3 <= degen_s2;
		end
	end

	// stage 4: common shift puts the leading one of the largest at NORM_MSB
	logic [5:0]            lead;
	logic [3:0][MAG_W-1:0] mag_sh;

	always_comb begin
		lead = '0;
		for (int b = 0; b < ABS_W; b++) begin
			if (mx_s3[b]) begin
				lead = 6'(b);
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (lead >= 6'(NORM_MSB)) begin
				mag_sh[i] = MAG_W'(abs_s3[i] >> (lead - 6'(NORM_MSB)));
			end else begin
				mag_sh[i] = MAG_W'(abs_s3[i] << (6'(NORM_MSB) - lead));
			end
		end
	end

	logic v_s4;
	dcmq_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.mag   <= mag_sh;
			side_s4.neg   <= neg_s3;
			side_s4.degen <= degen_s3;
		end
	end

	// stage 5: squares
	logic                    v_s5;
	dcmq_side_t              side_s5;
	logic [3:0][2*MAG_W-1:0] sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			for (int i = 0; i < 4; i++) begin
				sq_s5[i] <= side_s4.mag[i] * side_s4.mag[i];
			end
		end
	end

	// stage 6: sum of squares
	logic             v_s6;
	dcmq_side_t       side_s6;
	logic [SUM_W-1:0] sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			sum_s6  <= (SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]))
			         + (SUM_W'(sq_s5[2]) + SUM_W'(sq_s5[3]));
		end
	end

	logic             sq_valid;
	logic [NRM_W-1:0] sq_nrm;
	dcmq_side_t       sq_side;

	dcmq_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_sum    (sum_s6),
		.in_side   (side_s6),
		.out_valid (sq_valid),
		.out_nrm   (sq_nrm),
		.out_side  (sq_side)
	);

	logic                   dv_valid, dv_degen;
	logic [3:0][FRAC_BITS:0] dv_quo;
	logic [3:0]             dv_neg;

	dcmq_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_nrm    (sq_nrm),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_neg   (dv_neg),
		.out_degen (dv_degen)
	);

	// output register with signs applied
	logic [3:0][31:0] sgn;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sgn[i] = dv_neg[i] ? 32'(0) - 32'(dv_quo[i]) : 32'(dv_quo[i]);
		end
	end

	logic      rsp_valid_q;
	dcmq_out_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.quat_s     <= sgn[0];
			rsp_q.quat_x     <= sgn[1];
			rsp_q.quat_y     <= sgn[2];
			rsp_q.quat_z     <= sgn[3];
			rsp_q.degenerate <= dv_degen;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the trace branch never needs the radicand clamp
	a_trace_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && br_s2 == BR_TRACE |-> !degen_s2)
		else $error("clamp flagged on trace branch");

	// largest normalized magnitude sits at the top bit, so the root is at least 2^30
	a_norm_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> sq_nrm[NRM_W-1:NORM_MSB] != '0)
		else $error("square root below normalization floor");

	// the s and x quotients stay within one
	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid |-> (dv_quo[0] <= (FRAC_BITS+1)'(1) << FRAC_BITS)
		          && (dv_quo[1] <= (FRAC_BITS+1)'(1) << FRAC_BITS))
		else $error("quotient exceeds one");

	// a stalled pipe keeps its held result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rsp_q) && rsp_valid_q)
		else $error("result changed during stall");

endmodule
